// ----- src/bmhq_pkg.sv -----
package bmhq_pkg;

  // Heap geometry
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = CNT_W + 1;

  // Field widths
  localparam int KEY_W    = 17;
  localparam int TAG_W    = 15;
  localparam int STATUS_W = 2;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [TAG_W-1:0]    tag_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [CHILD_W-1:0]  child_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [STATUS_W-1:0] status_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } heap_word_t;

  // Item modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes
  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  localparam count_t FULL_COUNT = count_t'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_DEL_LD,
    ST_DEL_PICK,
    ST_DEL_CMP,
    ST_PUT
  } state_t;

  // Heap position (from 1) to memory address
  function automatic addr_t slot_addr(input child_t p);
    child_t tmp;
    tmp = p - child_t'(1);
    return tmp[ADDR_W-1:0];
  endfunction

endpackage

// ----- src/binary_min_heap_queue_top.sv -----
// Channel   Signals                                   Direction  Transfer
// ------------------------------------------------------------------------------------
// item      start, busy, mode, key, tag               in         start && !busy
// result    done, status, out_key, out_tag,           out        done, one cycle only
//           entry_count
//
// An insert climbs one level per compare state and ends with a final write; a delete loads the
// root and last entry, descends with a pick and a move state per level, then writes the
// moving entry; refusals answer in the cycle after the transfer.
// One memory with a write port and two registered read ports feeds one shared key
// comparator: a sift-up level is one compare, a sift-down level is two (pick, then move).
// Reset clears the count, the sequencer and done only; the heap memory is not cleared.
// busy is high while an item is in work; results cannot be held off by the receiver.
module binary_min_heap_queue_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              mode,
  input  bmhq_pkg::key_t    key,
  input  bmhq_pkg::tag_t    tag,
  output logic              done,
  output bmhq_pkg::status_t status,
  output bmhq_pkg::key_t    out_key,
  output bmhq_pkg::tag_t    out_tag,
  output bmhq_pkg::count_t  entry_count
);
  import bmhq_pkg::*;

  state_t     state, state_next;
  count_t     count, count_next;
  count_t     pos, pos_next;
  child_t     child, child_next;
  heap_word_t word, word_next;
  heap_word_t top, top_next;
  logic       cur_mode, cur_mode_next;
  logic       go_right, go_right_next;
  logic       done_next;
  status_t    status_next;
  key_t       out_key_next;
  tag_t       out_tag_next;

  // Memory ports
  heap_word_t mem [CAPACITY];
  logic       we;
  addr_t      waddr, ra_addr, rb_addr;
  heap_word_t wdata, rd_a, rd_b;

  // Shared comparator operands
  key_t       cmp_a, cmp_b;
  logic       cmp_lt;

  // Sift-down helpers
  heap_word_t pick_word;
  child_t     pick_pos;
  child_t     next_child;
  count_t     up_pos;

  // Heap memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[ra_addr];
    rd_b <= mem[rb_addr];
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Sequencer and datapath control
  always_comb begin
    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    child_next    = child;
    word_next     = word;
    top_next      = top;
    cur_mode_next = cur_mode;
    go_right_next = go_right;
    done_next     = 1'b0;
    status_next   = status;
    out_key_next  = out_key;
    out_tag_next  = out_tag;
    we            = 1'b0;
    waddr         = slot_addr(child_t'(pos));
    wdata         = word;
    ra_addr       = slot_addr(child);
    rb_addr       = slot_addr(child + child_t'(1));
    cmp_a         = word.key;
    cmp_b         = rd_a.key;
    pick_word     = rd_a;
    pick_pos      = child;
    next_child    = '0;
    up_pos        = pos >> 1;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cur_mode_next = mode;
          word_next     = '{key: key, tag: tag};
          if (mode == MODE_INSERT) begin
            if (count == FULL_COUNT) begin
              done_next    = 1'b1;
              status_next  = STAT_FULL;
              out_key_next = '0;
              out_tag_next = '0;
            end else begin
              count_next = count + count_t'(1);
              pos_next   = count + count_t'(1);
              // parent of the new slot
              ra_addr    = slot_addr(child_t'(count_next >> 1));
              state_next = (count == '0) ? ST_PUT : ST_INS_CMP;
            end
          end else begin
            if (count == '0) begin
              done_next    = 1'b1;
              status_next  = STAT_EMPTY;
              out_key_next = '0;
              out_tag_next = '0;
            end else begin
              count_next = count - count_t'(1);
              ra_addr    = slot_addr(child_t'(1));
              rb_addr    = slot_addr(child_t'(count));
              state_next = ST_DEL_LD;
            end
          end
        end
      end

      // Sift up: move the parent down while the new key is smaller
      ST_INS_CMP: begin
        if (cmp_lt) begin
          we       = 1'b1;
          wdata    = rd_a;
          pos_next = up_pos;
          ra_addr  = slot_addr(child_t'(up_pos >> 1));
          if (up_pos == count_t'(1)) begin
            state_next = ST_PUT;
          end
        end else begin
          state_next = ST_PUT;
        end
      end

      // Root and last entry arrive; start the sift-down from the root
      ST_DEL_LD: begin
        top_next   = rd_a;
        word_next  = rd_b;
        pos_next   = count_t'(1);
        child_next = child_t'(2);
        ra_addr    = slot_addr(child_t'(2));
        rb_addr    = slot_addr(child_t'(3));
        state_next = (child_t'(2) <= child_t'(count)) ? ST_DEL_PICK : ST_PUT;
      end

      // Sift down, first step: pick the smaller child (left on a tie);
      // the children are read again so they stay on the read ports
      ST_DEL_PICK: begin
        go_right_next = 1'b0;
        if (child < child_t'(count)) begin
          cmp_a         = rd_b.key;
          cmp_b         = rd_a.key;
          go_right_next = cmp_lt;
        end
        state_next = ST_DEL_CMP;
      end

      // Sift down, second step: move the child up if the last key is larger
      ST_DEL_CMP: begin
        pick_word  = go_right ? rd_b : rd_a;
        pick_pos   = go_right ? child + child_t'(1) : child;
        next_child = {pick_pos[CHILD_W-2:0], 1'b0};
        cmp_a      = pick_word.key;
        cmp_b      = word.key;
        if (cmp_lt) begin
          we         = 1'b1;
          wdata      = pick_word;
          pos_next   = pick_pos[CNT_W-1:0];
          child_next = next_child;
          ra_addr    = slot_addr(next_child);
          rb_addr    = slot_addr(next_child + child_t'(1));
          state_next = (next_child > child_t'(count)) ? ST_PUT : ST_DEL_PICK;
        end else begin
          state_next = ST_PUT;
        end
      end

      // Final write of the moving entry and the result
      ST_PUT: begin
        we          = 1'b1;
        done_next   = 1'b1;
        status_next = STAT_DONE;
        if (cur_mode == MODE_DELETE) begin
          out_key_next = top.key;
          out_tag_next = top.tag;
        end else begin
          out_key_next = '0;
          out_tag_next = '0;
        end
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    child    <= child_next;
    word     <= word_next;
    top      <= top_next;
    cur_mode <= cur_mode_next;
    go_right <= go_right_next;
    status   <= status_next;
    out_key  <= out_key_next;
    out_tag  <= out_tag_next;
  end

  assign busy        = (state != ST_IDLE);
  assign entry_count = count;

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while an item is still in work");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond capacity");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_INSERT && count == FULL_COUNT)
      |=> (done && status == STAT_FULL && count == FULL_COUNT))
    else $error("insert into a full heap not refused");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_EMPTY) |-> (entry_count == '0))
    else $error("empty refusal with entries held");

endmodule
